// File: hw/rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared constants for the multichannel moving average: the fixed widths of
// the stream fields and of the packed beats.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

    // Field widths of one input beat and one output beat.
    localparam int CH_FIELD_W     = 3;
    localparam int SAMPLE_FIELD_W = 12;
    localparam int AVG_FIELD_W    = 12;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((CH_FIELD_W + SAMPLE_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((AVG_FIELD_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// File: hw/rtl/multichannel_moving_average.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Boxcar moving average over a shared window for several converter channels.
// ----------------------------------------------------------------------------
// Stages: stage 1, stage 2 and the output register. One beat per cycle unless
// the output stalls; one memory read per beat and one write per in-range beat.
// Reset: i_rst_n is synchronous and active low. It clears the window position,
// the channel totals and the pipeline, then a clearing pass writes zero to all
// CHANNEL_COUNT * WINDOW_LENGTH sample entries (96 entries at the defaults),
// one entry per cycle, while s_tready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_moving_average #(
    parameter int CHANNEL_COUNT = 8,
    parameter int WINDOW_LENGTH = 12,
    parameter int SAMPLE_BITS   = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input stream. tdata fields from bit 0: channel_index[2:0],
    // sample_value[11:0], zero padding.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mma_pkg::S_TDATA_W-1:0]  s_tdata,
    // Output stream. tdata fields from bit 0: average_value[11:0], zero padding.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [mma_pkg::M_TDATA_W-1:0]       m_tdata
);

    // Sample memory holds one entry per (channel, window slot), laid out
    // channel-major so that the address is channel * WINDOW_LENGTH + slot.
    localparam int DEPTH = CHANNEL_COUNT * WINDOW_LENGTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int CIW   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int LW    = $clog2(WINDOW_LENGTH);
    // A total is the sum of WINDOW_LENGTH samples, so it needs LW extra bits.
    localparam int TW    = SAMPLE_BITS + LW;

    // Division by WINDOW_LENGTH is a multiplication by a rounded-up reciprocal.
    // With SHIFT = TW + ceil(log2(WINDOW_LENGTH)) the quotient is exact for
    // every TW-bit total.
    localparam int SHIFT = TW + LW;
    localparam int PRW   = 2 * TW + 1;
    localparam int QW    = PRW - SHIFT;
    localparam logic [TW:0] MULT = (TW + 1)'(((64'd1 << SHIFT) + 64'(WINDOW_LENGTH)
                                             - 64'd1) / 64'(WINDOW_LENGTH));
    localparam logic [TW-1:0] MAX_TOTAL =
        TW'(64'(WINDOW_LENGTH) * ((64'd1 << SAMPLE_BITS) - 64'd1));

    // Unpack the input beat.
    logic [mma_pkg::CH_FIELD_W-1:0]     in_ch;
    logic [mma_pkg::SAMPLE_FIELD_W-1:0] in_sample;
    assign in_ch     = s_tdata[mma_pkg::CH_FIELD_W-1:0];
    assign in_sample = s_tdata[mma_pkg::CH_FIELD_W +: mma_pkg::SAMPLE_FIELD_W];

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_addr;
    logic [PW-1:0]    r_pos;

    // Stage 1: the memory read data for this beat is valid here.
    logic             r_s1_v;
    logic             r_s1_ok;
    logic [CIW-1:0]   r_s1_ch;
    logic [AW-1:0]    r_s1_addr;
    logic [SAMPLE_BITS-1:0] r_s1_smp;
    logic             r_s1_fwd;
    logic [SAMPLE_BITS-1:0] r_s1_fwd_smp;
    logic [SAMPLE_BITS-1:0] r_rd_data;

    // Stage 2: the updated total, waiting for the divide.
    logic             r_s2_v;
    logic             r_s2_ok;
    logic [TW-1:0]    r_s2_tot;

    // Output register.
    logic             r_out_v;
    logic [mma_pkg::AVG_FIELD_W-1:0] r_out_avg;

    logic [TW-1:0]    r_totals [CHANNEL_COUNT];
    logic [SAMPLE_BITS-1:0] mem [DEPTH];

    // ------------------------------------------------------------------
    // Pipeline flow. Each stage moves on when the stage after it is empty
    // or moving, so bubbles are squeezed out even while the output stalls.
    // ------------------------------------------------------------------
    logic out_free, s2_adv, s2_free, s1_adv, s1_free, accept;

    assign out_free = !r_out_v || m_tready;
    assign s2_adv   = r_s2_v && out_free;
    assign s2_free  = !r_s2_v || out_free;
    assign s1_adv   = r_s1_v && s2_free;
    assign s1_free  = !r_s1_v || s2_free;
    assign s_tready = s1_free && !r_clr_busy;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Accept side: address generation and the shared window position.
    // Channels at or above CHANNEL_COUNT change nothing and yield zero.
    // ------------------------------------------------------------------
    logic                   in_ok;
    logic [AW-1:0]          in_addr;
    logic [SAMPLE_BITS-1:0] in_smp;
    logic                   pos_adv;
    logic [PW-1:0]          n_pos;

    assign in_ok   = 32'(in_ch) < CHANNEL_COUNT;
    assign in_addr = AW'(32'(in_ch) * WINDOW_LENGTH + 32'(r_pos));
    assign in_smp  = SAMPLE_BITS'(in_sample);
    assign pos_adv = accept && in_ok && (32'(in_ch) == CHANNEL_COUNT - 1);

    always_comb begin
        n_pos = r_pos;
        if (pos_adv) begin
            if (32'(r_pos) == WINDOW_LENGTH - 1) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + PW'(1);
            end
        end
    end

    // The beat in stage 1 writes its entry on the edge at which it leaves.
    // A beat accepted on that same edge that reads the same entry would see
    // the stale word, so the fresh sample is carried along instead.
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic                   fwd_hit;

    assign fwd_hit   = s1_adv && r_s1_ok && (r_s1_addr == in_addr);
    assign mem_we    = r_clr_busy || (s1_adv && r_s1_ok);
    assign mem_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign mem_wdata = r_clr_busy ? '0 : r_s1_smp;

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_rd_data <= mem[in_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 arithmetic: drop the oldest sample, add the new one.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] old_smp;
    logic [TW-1:0]          n_total;

    assign old_smp = r_s1_fwd ? r_s1_fwd_smp : r_rd_data;
    assign n_total = r_totals[r_s1_ch] - TW'(old_smp) + TW'(r_s1_smp);

    // ------------------------------------------------------------------
    // Output arithmetic: total divided by WINDOW_LENGTH, truncated, then
    // cut to the 12-bit field.
    // ------------------------------------------------------------------
    logic [PRW-1:0] prod;
    logic [QW-1:0]  quot;

    assign prod = PRW'(r_s2_tot) * PRW'(MULT);
    assign quot = prod[PRW-1:SHIFT];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_pos      <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_out_v    <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_totals[i] <= '0;
            end
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_pos <= n_pos;

            if (s1_free) begin
                r_s1_v <= accept;
            end
            if (s2_free) begin
                r_s2_v <= s1_adv;
            end
            if (out_free) begin
                r_out_v <= s2_adv;
            end

            if (s1_adv && r_s1_ok) begin
                r_totals[r_s1_ch] <= n_total;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ok      <= in_ok;
            r_s1_ch      <= CIW'(32'(in_ch));
            r_s1_addr    <= in_addr;
            r_s1_smp     <= in_smp;
            r_s1_fwd     <= fwd_hit;
            r_s1_fwd_smp <= r_s1_smp;
        end
        if (s1_adv) begin
            r_s2_ok  <= r_s1_ok;
            r_s2_tot <= r_s1_ok ? n_total : '0;
        end
        if (s2_adv) begin
            r_out_avg <= r_s2_ok ? mma_pkg::AVG_FIELD_W'(quot) : '0;
        end
    end

    assign m_tvalid = r_out_v;
    assign m_tdata  = mma_pkg::M_TDATA_W'(r_out_avg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !(s_tvalid && s_tready))
        else $error("input beat accepted during the clearing pass");

    a_pos_in_window: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < WINDOW_LENGTH)
        else $error("window position out of range");

    a_total_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_s2_tot <= MAX_TOTAL))
        else $error("channel total exceeds a full window of maximum samples");

    a_bad_channel_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && !r_s2_ok && out_free) |=> (r_out_avg == '0))
        else $error("out-of-range channel produced a nonzero average");

    a_fwd_needs_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (accept && fwd_hit) |-> (mem_we && !r_clr_busy))
        else $error("forwarding without a matching sample write");

endmodule

`default_nettype wire

// File: dv/tb_multichannel_moving_average.sv
// ----------------------------------------------------------------------------
// tb_multichannel_moving_average
// Self-checking bench for the multichannel boxcar average. A table of directed
// beats runs first: reset contents, full-scale samples, every channel and a
// full window wrap on the last channel. Random beats follow, mostly in channel
// scan order as a converter sequencer would send them, under three idling
// patterns and one long output stall. Every output beat is checked against a
// typed table average or a behavioral copy of the window and total arrays.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multichannel_moving_average;

    // Block configuration; the bench keeps its own copy of the window state
    // sized from these.
    localparam int CHANNELS = 8;
    localparam int WINDOW   = 12;
    localparam int SAMPLE_W = 12;

    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_BEATS = 800;
    localparam int HOLD_CYCLES  = 200;
    // Extra cycles after the last pending average catch stray beats.
    localparam int DRAIN_CYCLES = 20;
    // The clearing pass, the long hold and 800 beats with heavy idling all fit well
    // within this limit.
    localparam int CYCLE_LIMIT  = 100000;

    localparam logic [mma_pkg::SAMPLE_FIELD_W-1:0] FULL_SCALE = '1;

    // Which side idles, and how often, while the random beats run.
    typedef enum logic [1:0] {
        RX_MOSTLY_IDLE,
        TX_MOSTLY_IDLE,
        NO_IDLE
    } t_idle_mode;

    // One row of the directed table. When has_average is set the expected
    // average is the typed value; otherwise it comes from the predictor.
    typedef struct packed {
        logic [mma_pkg::CH_FIELD_W-1:0]     channel;
        logic [mma_pkg::SAMPLE_FIELD_W-1:0] sample;
        logic                               has_average;
        logic [mma_pkg::AVG_FIELD_W-1:0]    average;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 23;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // Fields from bit 0: channel_index[2:0], sample_value[11:0], zero padding.
    logic [mma_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // Fields from bit 0: average_value[11:0], zero padding.
    logic [mma_pkg::M_TDATA_W-1:0] m_tdata;

    // Bench copy of the block state.
    logic [SAMPLE_W-1:0] window_samples [CHANNELS][WINDOW];
    logic [15:0]         channel_sums   [CHANNELS];
    int unsigned         window_slot;

    // Averages owed by the block, oldest first.
    logic [mma_pkg::AVG_FIELD_W-1:0] pending_averages [$];

    t_idle_mode  idle_mode = RX_MOSTLY_IDLE;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Reset contents first, then a full-scale sample written twice into the
    // same slot of channel 0 (the old value must be taken out of the sum),
    // one beat for each remaining channel, and thirteen full-scale beats on
    // the last channel: they step the shared slot through the whole window,
    // reach the largest possible sum and wrap back to the first slot.
    t_directed_row directed_table [DIRECTED_ROWS] = '{
        '{3'd0, 12'd0,    1'b1, 12'd0},
        '{3'd0, 12'd4095, 1'b1, 12'd341},
        '{3'd0, 12'd4095, 1'b1, 12'd341},
        '{3'd1, 12'd12,   1'b1, 12'd1},
        '{3'd2, 12'd2048, 1'b0, 12'd0},
        '{3'd3, 12'd1,    1'b1, 12'd0},
        '{3'd4, 12'd4094, 1'b0, 12'd0},
        '{3'd5, 12'd1365, 1'b0, 12'd0},
        '{3'd6, 12'd2730, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b1, 12'd341},
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b0, 12'd0},
        '{3'd7, 12'd4095, 1'b1, 12'd4095},
        '{3'd7, 12'd4095, 1'b1, 12'd4095},
        '{3'd0, 12'd0,    1'b0, 12'd0}
    };

    multichannel_moving_average #(
        .CHANNEL_COUNT (CHANNELS),
        .WINDOW_LENGTH (WINDOW),
        .SAMPLE_BITS   (SAMPLE_W)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Updates the bench state with one accepted sample and returns the
    // average the block must produce for it. The slot is shared by all
    // channels and steps forward only on the last channel.
    function automatic logic [mma_pkg::AVG_FIELD_W-1:0] window_average(
        input logic [mma_pkg::CH_FIELD_W-1:0]     channel,
        input logic [mma_pkg::SAMPLE_FIELD_W-1:0] sample
    );
        int unsigned slot;
        logic [15:0] sum;
        if (int'(channel) >= CHANNELS) begin
            return '0;
        end
        slot = (window_slot >= WINDOW) ? 0 : window_slot;
        sum  = channel_sums[channel] - 16'(window_samples[channel][slot]) + 16'(sample);
        channel_sums[channel]         = sum;
        window_samples[channel][slot] = sample;
        if (int'(channel) == CHANNELS - 1) begin
            window_slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
        end else begin
            window_slot = slot;
        end
        return mma_pkg::AVG_FIELD_W'(sum / 16'(WINDOW));
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Offers one beat, called and returning at a falling edge. Idle cycles
    // go in front of the beat according to the current idling mode. The
    // expectation is recorded at the rising edge that accepts the beat.
    task automatic offer_sample(
        input logic [mma_pkg::CH_FIELD_W-1:0]     channel,
        input logic [mma_pkg::SAMPLE_FIELD_W-1:0] sample,
        input logic                               has_average,
        input logic [mma_pkg::AVG_FIELD_W-1:0]    typed_average
    );
        int unsigned idle_pct;
        logic [mma_pkg::AVG_FIELD_W-1:0] predicted;
        case (idle_mode)
            RX_MOSTLY_IDLE: idle_pct = 24;
            TX_MOSTLY_IDLE: idle_pct = 70;
            default:        idle_pct = 0;
        endcase
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mma_pkg::S_TDATA_W'({sample, channel});
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        predicted = window_average(channel, sample);
        pending_averages.push_back(has_average ? typed_average : predicted);
        @(negedge i_clk);
    endtask

    // Output side. The hold-off at the start of the no-idle stretch keeps
    // m_tready low long enough for the pipeline to fill and push back on
    // the input while the sender keeps offering beats.
    initial begin : output_pacing
        int unsigned hold_left;
        bit          hold_done;
        int unsigned idle_pct;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_mode == NO_IDLE && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            case (idle_mode)
                RX_MOSTLY_IDLE: idle_pct = 70;
                TX_MOSTLY_IDLE: idle_pct = 24;
                default:        idle_pct = 0;
            endcase
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Each output beat is compared with the oldest pending average.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_averages.size() == 0) begin
                report_mismatch($sformatf("average %0d with nothing pending",
                                          m_tdata[mma_pkg::AVG_FIELD_W-1:0]));
            end else begin
                if (m_tdata[mma_pkg::AVG_FIELD_W-1:0] !== pending_averages[0]) begin
                    report_mismatch($sformatf("average_value got %0d expected %0d",
                                              m_tdata[mma_pkg::AVG_FIELD_W-1:0],
                                              pending_averages[0]));
                end
                void'(pending_averages.pop_front());
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d averages pending", $realtime,
                     pending_averages.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned scan_channel;
        int unsigned beat_count;
        logic [mma_pkg::CH_FIELD_W-1:0]     channel;
        logic [mma_pkg::SAMPLE_FIELD_W-1:0] sample;

        for (int c = 0; c < CHANNELS; c++) begin
            channel_sums[c] = '0;
            for (int w = 0; w < WINDOW; w++) begin
                window_samples[c][w] = '0;
            end
        end
        window_slot  = 0;
        scan_channel = 0;

        // Synchronous reset, released at a falling edge. The block then runs
        // its clearing pass with s_tready low; the sender simply waits.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_mode = RX_MOSTLY_IDLE;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            offer_sample(directed_table[r].channel, directed_table[r].sample,
                         directed_table[r].has_average, directed_table[r].average);
        end

        // Random beats in three stretches, one per idling mode. Most beats
        // follow the channel scan order; the rest jump to a random channel.
        // Samples mix full-scale, zero, a steady per-channel level with a
        // little noise, and uniform values.
        for (beat_count = 0; beat_count < RANDOM_BEATS; beat_count++) begin
            if (beat_count == RANDOM_BEATS / 3) begin
                idle_mode = TX_MOSTLY_IDLE;
            end else if (beat_count == 2 * RANDOM_BEATS / 3) begin
                idle_mode = NO_IDLE;
            end
            if ($urandom_range(9) < 7) begin
                channel      = mma_pkg::CH_FIELD_W'(scan_channel);
                scan_channel = (scan_channel + 1) % CHANNELS;
            end else begin
                channel = mma_pkg::CH_FIELD_W'($urandom_range(CHANNELS - 1));
            end
            case ($urandom_range(7))
                0:       sample = '0;
                1:       sample = FULL_SCALE;
                2, 3:    sample = mma_pkg::SAMPLE_FIELD_W'(int'(channel) * 500
                                                           + $urandom_range(63));
                default: sample = mma_pkg::SAMPLE_FIELD_W'($urandom);
            endcase
            offer_sample(channel, sample, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_averages.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mma_pkg.sv
hw/rtl/multichannel_moving_average.sv
dv/tb_multichannel_moving_average.sv
